### rtl/core/fgb_pkg.sv
// Shared constants, codes and types for the feature grid bucketing block.
// No dependencies; fgb_count_ram, fgb_div and the top level refer to it by scoped names.
package fgb_pkg;

  localparam int CELLS        = 256;
  localparam int MAX_PER_CELL = 8;

  localparam int CELL_W  = $clog2(CELLS);
  localparam int SLOT_W  = $clog2(MAX_PER_CELL);
  localparam int CNT_W   = $clog2(MAX_PER_CELL + 1);
  localparam int SLOT_AW = CELL_W + SLOT_W;
  localparam int SLOTS   = CELLS * MAX_PER_CELL;

  localparam int PIX_W   = 12;
  localparam int COORD_W = 13;
  localparam int DIV_W   = 13;
  localparam int POS_W   = 12;
  localparam int TAG_W   = 16;
  localparam int ENTRY_W = POS_W + TAG_W;
  localparam int LIM_W   = 4;
  localparam int DRAIN_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CELL_WIDTH   = 3'd0;
  localparam cfg_idx_t REG_CELL_HEIGHT  = 3'd1;
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 3'd2;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 3'd3;
  localparam cfg_idx_t REG_CELL_LIMIT   = 3'd4;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] with_depth;
    logic [CNT_W-1:0] no_depth;
  } cnt_pair_t;

  // request to the per-cell count store
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [CELL_W-1:0] addr;
    cnt_pair_t         wdata;
  } cnt_req_t;

endpackage

### rtl/core/fgb_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies; contents undefined until written.
module fgb_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/core/fgb_count_ram.sv
// Per-cell feature counts (depth / no depth), registered read.
// Depends on fgb_pkg. Valid bits cleared by reset make unwritten cells read zero.
module fgb_count_ram (
  input  logic              clk,
  input  logic              rst,
  input  fgb_pkg::cnt_req_t req,
  output fgb_pkg::cnt_pair_t rdata
);

  fgb_pkg::cnt_pair_t mem [fgb_pkg::CELLS];
  logic [fgb_pkg::CELLS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.wr) begin
      vld[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end else if (req.rd) begin
      rdata <= vld[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule

### rtl/core/fgb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fgb_pkg for widths; divisor must be non-zero.
module fgb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fgb_pkg::DIV_W-1:0] dividend,
  input  logic [fgb_pkg::PIX_W-1:0] divisor,
  output logic                      busy,
  output logic [fgb_pkg::DIV_W-1:0] quotient
);

  localparam int STEP_W = $clog2(fgb_pkg::DIV_W + 1);

  logic [fgb_pkg::DIV_W-1:0] rem;
  logic [fgb_pkg::DIV_W-1:0] dsr;
  logic [STEP_W-1:0]         steps;
  logic [fgb_pkg::DIV_W-1:0] shifted;
  logic                      fits;

  assign shifted = {rem[fgb_pkg::DIV_W-2:0], quotient[fgb_pkg::DIV_W-1]};
  assign fits    = shifted >= dsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(fgb_pkg::DIV_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= fgb_pkg::DIV_W'(divisor);
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? shifted - dsr : shifted;
      quotient <= {quotient[fgb_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

### rtl/core/feature_grid_bucketing_top.sv
// Feature grid bucketing, top level: sequencer, config registers, dividers, stores.
// Depends on fgb_pkg, fgb_ram, fgb_count_ram and fgb_div.
//
// Input items (item_valid / item_stall) are an add (func = 0) that files one
// keypoint into its grid cell, or a drain (func = 1) that emits the kept
// features of drain_cell and empties that cell. Result items leave on
// result_valid / result_stall; last_of_cell marks the final one of a drain.
// An add, or a drain of an empty cell, gives no result item.
// An add on the image holds the input through the three dividers side by
// side (quotient steps, then a state to see them done), a multiply, a
// sum/range check with the count read and a write back; a point past the
// grid leaves after the sum, one off the image at once.
// A drain is the count read, then a slot read and an output load per result
// (one RAM port each).
// item_stall is high while an item is in work.
// Reset (rst, synchronous) restores 32x32 cells, 640x480 image, limit 4 and
// marks every cell empty at once; slot RAMs hold no reset.
// A stalled result holds its payload; the drain waits with its next slot
// read parked in the RAM output register.
module feature_grid_bucketing_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write_en,
  input  logic [fgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fgb_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic                           func,
  input  logic [fgb_pkg::POS_W-1:0]      feature_position,
  input  logic [fgb_pkg::TAG_W-1:0]      feature_tag,
  input  logic signed [fgb_pkg::COORD_W-1:0] col_pixel,
  input  logic signed [fgb_pkg::COORD_W-1:0] row_pixel,
  input  logic                           depth_ok,
  input  logic [fgb_pkg::DRAIN_W-1:0]    drain_cell,
  // result items
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [fgb_pkg::POS_W-1:0]      out_position,
  output logic [fgb_pkg::TAG_W-1:0]      out_tag,
  output logic                           out_depth_ok,
  output logic [fgb_pkg::DRAIN_W-1:0]    out_cell,
  output logic                           last_of_cell
);

  localparam int PROD_W = 2 * fgb_pkg::DIV_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CNT_W  = fgb_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_SUM, S_CNT, S_DCNT, S_RD, S_LD
  } state_t;

  state_t state;

  // configuration registers
  logic [fgb_pkg::PIX_W-1:0] cell_width, cell_height, image_width, image_height;
  logic [fgb_pkg::LIM_W-1:0] per_cell_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width     <= fgb_pkg::PIX_W'(32);
      cell_height    <= fgb_pkg::PIX_W'(32);
      image_width    <= fgb_pkg::PIX_W'(640);
      image_height   <= fgb_pkg::PIX_W'(480);
      per_cell_limit <= fgb_pkg::LIM_W'(4);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        fgb_pkg::REG_CELL_WIDTH:   cell_width     <= cfg_data;
        fgb_pkg::REG_CELL_HEIGHT:  cell_height    <= cfg_data;
        fgb_pkg::REG_IMAGE_WIDTH:  image_width    <= cfg_data;
        fgb_pkg::REG_IMAGE_HEIGHT: image_height   <= cfg_data;
        fgb_pkg::REG_CELL_LIMIT:   per_cell_limit <= cfg_data[fgb_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // zero cell sizes act as one; the cell limit is capped at MAX_PER_CELL
  logic [fgb_pkg::PIX_W-1:0] cw_eff, ch_eff;
  logic [fgb_pkg::LIM_W-1:0] lim_eff;
  assign cw_eff  = (cell_width == '0)  ? fgb_pkg::PIX_W'(1) : cell_width;
  assign ch_eff  = (cell_height == '0) ? fgb_pkg::PIX_W'(1) : cell_height;
  assign lim_eff = (per_cell_limit > fgb_pkg::LIM_W'(fgb_pkg::MAX_PER_CELL))
                 ? fgb_pkg::LIM_W'(fgb_pkg::MAX_PER_CELL) : per_cell_limit;

  // input screening
  logic accept, is_drain, drain_bad, point_out;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign is_drain   = (func == fgb_pkg::FUNC_DRAIN);
  assign drain_bad  = 32'(drain_cell) >= fgb_pkg::CELLS;
  assign point_out  = col_pixel[fgb_pkg::COORD_W-1] || row_pixel[fgb_pkg::COORD_W-1]
                   || (col_pixel[fgb_pkg::PIX_W-1:0] >= image_width)
                   || (row_pixel[fgb_pkg::PIX_W-1:0] >= image_height);

  // dividers: column index, row index, column count (ceiling)
  logic                      div_start;
  logic [2:0]                div_busy;
  logic [fgb_pkg::DIV_W-1:0] col_idx, row_idx, ncols;
  logic [fgb_pkg::DIV_W-1:0] ncols_num;

  assign div_start = accept && !is_drain && !point_out;
  assign ncols_num = fgb_pkg::DIV_W'(image_width) + fgb_pkg::DIV_W'(cw_eff)
                   - fgb_pkg::DIV_W'(1);

  fgb_div u_div_col (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({1'b0, col_pixel[fgb_pkg::PIX_W-1:0]}), .divisor(cw_eff),
    .busy(div_busy[0]), .quotient(col_idx)
  );

  fgb_div u_div_row (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({1'b0, row_pixel[fgb_pkg::PIX_W-1:0]}), .divisor(ch_eff),
    .busy(div_busy[1]), .quotient(row_idx)
  );

  fgb_div u_div_ncols (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(ncols_num), .divisor(cw_eff),
    .busy(div_busy[2]), .quotient(ncols)
  );

  // item context
  fgb_pkg::entry_t            entry_q;
  logic                       depth_q;
  logic [fgb_pkg::CELL_W-1:0] cell_q;
  logic [PROD_W-1:0]          prod;
  logic [SUM_W-1:0]           cell_sum;
  logic                       cell_over;

  assign cell_sum  = SUM_W'(prod) + SUM_W'(col_idx);
  assign cell_over = cell_sum >= SUM_W'(fgb_pkg::CELLS);

  // drain context
  logic [CNT_W-1:0] vcnt_q, n_q, k;
  logic [CNT_W-1:0] k_off;
  logic             use_valid, use_valid_q;
  assign k_off     = k - vcnt_q;
  assign use_valid = k < vcnt_q;

  // count store
  fgb_pkg::cnt_req_t  cnt_req;
  fgb_pkg::cnt_pair_t cnt_rdata;

  fgb_count_ram u_counts (
    .clk(clk), .rst(rst), .req(cnt_req), .rdata(cnt_rdata)
  );

  logic [CNT_W-1:0] sel_cnt;
  logic             slot_free;
  assign sel_cnt   = depth_q ? cnt_rdata.with_depth : cnt_rdata.no_depth;
  assign slot_free = sel_cnt < CNT_W'(fgb_pkg::MAX_PER_CELL);

  logic [CNT_W:0]   cnt_total;
  logic [CNT_W-1:0] n_emit;
  assign cnt_total = {1'b0, cnt_rdata.with_depth} + {1'b0, cnt_rdata.no_depth};
  assign n_emit    = ((CNT_W + 1)'(lim_eff) < cnt_total) ? CNT_W'(lim_eff)
                                                         : CNT_W'(cnt_total);

  // slot stores
  logic                        vs_en, vs_we, ns_en, ns_we;
  logic [fgb_pkg::SLOT_AW-1:0] slot_addr;
  logic [fgb_pkg::ENTRY_W-1:0] vs_rdata, ns_rdata;

  fgb_ram #(.WIDTH(fgb_pkg::ENTRY_W), .DEPTH(fgb_pkg::SLOTS)) u_valid_slots (
    .clk(clk), .en(vs_en), .we(vs_we), .addr(slot_addr),
    .wdata(entry_q), .rdata(vs_rdata)
  );

  fgb_ram #(.WIDTH(fgb_pkg::ENTRY_W), .DEPTH(fgb_pkg::SLOTS)) u_nodepth_slots (
    .clk(clk), .en(ns_en), .we(ns_we), .addr(slot_addr),
    .wdata(entry_q), .rdata(ns_rdata)
  );

  logic out_free, out_load;
  assign out_free = !result_valid || !result_stall;
  assign out_load = (state == S_LD) && out_free;

  always_comb begin
    cnt_req   = '0;
    vs_en     = 1'b0;
    vs_we     = 1'b0;
    ns_en     = 1'b0;
    ns_we     = 1'b0;
    slot_addr = {cell_q, sel_cnt[fgb_pkg::SLOT_W-1:0]};
    case (state)
      S_IDLE: begin
        if (accept && is_drain && !drain_bad) begin
          cnt_req.rd   = 1'b1;
          cnt_req.addr = drain_cell[fgb_pkg::CELL_W-1:0];
        end
      end
      S_SUM: begin
        if (!cell_over) begin
          cnt_req.rd   = 1'b1;
          cnt_req.addr = cell_sum[fgb_pkg::CELL_W-1:0];
        end
      end
      S_CNT: begin
        if (slot_free) begin
          cnt_req.wr    = 1'b1;
          cnt_req.addr  = cell_q;
          cnt_req.wdata = cnt_rdata;
          if (depth_q) begin
            cnt_req.wdata.with_depth = sel_cnt + 1'b1;
            vs_en = 1'b1;
            vs_we = 1'b1;
          end else begin
            cnt_req.wdata.no_depth = sel_cnt + 1'b1;
            ns_en = 1'b1;
            ns_we = 1'b1;
          end
        end
      end
      S_DCNT: begin
        cnt_req.wr   = 1'b1;
        cnt_req.addr = cell_q;
      end
      S_RD: begin
        if (use_valid) begin
          vs_en     = 1'b1;
          slot_addr = {cell_q, k[fgb_pkg::SLOT_W-1:0]};
        end else begin
          ns_en     = 1'b1;
          slot_addr = {cell_q, k_off[fgb_pkg::SLOT_W-1:0]};
        end
      end
      default: ;
    endcase
  end

  fgb_pkg::entry_t rd_entry;
  assign rd_entry = use_valid_q ? vs_rdata : ns_rdata;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            entry_q <= '{position: feature_position, tag: feature_tag};
            depth_q <= depth_ok;
            cell_q  <= drain_cell[fgb_pkg::CELL_W-1:0];
            if (is_drain) begin
              if (!drain_bad) state <= S_DCNT;
            end else if (!point_out) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_busy == '0) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= row_idx * ncols;
          state <= S_SUM;
        end
        S_SUM: begin
          cell_q <= cell_sum[fgb_pkg::CELL_W-1:0];
          state  <= cell_over ? S_IDLE : S_CNT;
        end
        S_CNT: begin
          state <= S_IDLE;
        end
        S_DCNT: begin
          vcnt_q <= cnt_rdata.with_depth;
          n_q    <= n_emit;
          k      <= '0;
          state  <= (n_emit == '0) ? S_IDLE : S_RD;
        end
        S_RD: begin
          use_valid_q <= use_valid;
          state       <= S_LD;
        end
        S_LD: begin
          if (out_free) begin
            result_valid <= 1'b1;
            out_position <= rd_entry.position;
            out_tag      <= rd_entry.tag;
            out_depth_ok <= use_valid_q;
            out_cell     <= fgb_pkg::DRAIN_W'(cell_q);
            last_of_cell <= (k == n_q - 1'b1);
            k            <= k + 1'b1;
            state        <= (k == n_q - 1'b1) ? S_IDLE : S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/fgb_checker.sv
// Port-level checks for feature_grid_bucketing_top, attached by bind.
// Depends on the top level's port names only.
module fgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        func,
  input logic        result_valid,
  input logic        result_stall,
  input logic [11:0] out_position,
  input logic [15:0] out_tag,
  input logic        out_depth_ok,
  input logic [7:0]  out_cell,
  input logic        last_of_cell
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid
      && $stable({out_position, out_tag, out_depth_ok, out_cell, last_of_cell}))
    else $error("stalled result changed");

  // reset empties the result register
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown after reset");

  // drain not finished while a non-final result is on show
  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_cell |-> item_stall)
    else $error("item taken mid-drain");

  // a drain always occupies the block for its count read
  a_drain_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && func |=> item_stall)
    else $error("drain not held");

endmodule

bind feature_grid_bucketing_top fgb_checker u_fgb_checker (.*);
